// ===== hw/rtl/fortt_pkg.sv =====
// Shared types, constants and helpers for the frequency-ordered record type table.
// Used by fortt_ctrl, fortt_datapath and the top level; depends on nothing.
package fortt_pkg;

   localparam int CLASS_W = 16;
   localparam int TYPE_W  = 16;
   localparam int KIND_W  = 4;
   localparam int COUNT_W = 32;
   localparam int LIMIT_W = 24;
   localparam int LOOKUP_W = 25;
   localparam int INIT_ENTRIES = 14;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 24'd100000;
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = 32'hFFFF_FFFF;
   localparam logic [LOOKUP_W-1:0] LOOKUP_MAX  = 25'h1FF_FFFF;
   localparam logic [CLASS_W-1:0]  FILL_CLASS  = 16'hFFFF;
   localparam logic [TYPE_W-1:0]   FILL_TYPE   = 16'hFFFF;

   localparam logic [CLASS_W-1:0] INIT_CLASS [INIT_ENTRIES] = '{
      16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
   };
   localparam logic [TYPE_W-1:0] INIT_TYPE [INIT_ENTRIES] = '{
      16'd1,  16'd2,  16'd5,  16'd6,  16'd12, 16'd33, 16'd28,
      16'd15, 16'd46, 16'd16, 16'd47, 16'd43, 16'd10, 16'd48
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;          // capture the request and update the lookup counter
      logic sort_pass;     // one odd-even compare-and-swap pass
      logic sort_odd;      // pass works on odd pairs
      logic clear_counts;  // zero all slot counts after the last pass
      logic scan;          // rotate the table by one slot and test the head
      logic emit;          // load the response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_sort;     // lookup counter has passed the limit
      logic out_free;      // response register can take a new transaction
   } status_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [CLASS_W-1:0] init_class(input int idx);
      if (idx < INIT_ENTRIES) begin
         return INIT_CLASS[4'(idx)];
      end
      return FILL_CLASS;
   endfunction

   function automatic logic [TYPE_W-1:0] init_type(input int idx);
      if (idx < INIT_ENTRIES) begin
         return INIT_TYPE[4'(idx)];
      end
      return FILL_TYPE;
   endfunction

endpackage

// ===== hw/rtl/fortt_ctrl.sv =====
// Sequencing state machine for the record type table: accept, sort, scan, emit.
// Depends on fortt_pkg for the state, command and status types.
module fortt_ctrl #(
   parameter int TABLE_SLOTS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  fortt_pkg::status_type status,
   output fortt_pkg::cmd_type    cmd
);
   import fortt_pkg::*;

   localparam int SW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [SW-1:0] LAST_STEP = SW'(TABLE_SLOTS - 1);

   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   // State and step registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = status.need_sort ? ST_SORT : ST_SCAN;
            end
         end
         ST_SORT: begin
            cmd.sort_pass = 1'b1;
            cmd.sort_odd  = step_ff[0];
            if (step_ff == LAST_STEP) begin
               cmd.clear_counts = 1'b1;
               step_in          = '0;
               state_in         = ST_SCAN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/fortt_datapath.sv =====
// Slot table, rotating scan, odd-even sort network, counters and response register.
// Depends on fortt_pkg for types, constants and the saturating increment.
module fortt_datapath #(
   parameter int TABLE_SLOTS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fortt_pkg::cmd_type    cmd,
   output fortt_pkg::status_type status,
   input  logic [31:0]          req_tdata,
   input  logic                 csr_we,
   input  logic [23:0]          csr_wdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,
   output logic [0:0]           rsp_tuser
);
   import fortt_pkg::*;

   localparam logic [KIND_W-1:0] DEFAULT_KIND = KIND_W'(TABLE_SLOTS);

   logic [CLASS_W-1:0]  cls_ff [TABLE_SLOTS];
   logic [CLASS_W-1:0]  cls_in [TABLE_SLOTS];
   logic [TYPE_W-1:0]   typ_ff [TABLE_SLOTS];
   logic [TYPE_W-1:0]   typ_in [TABLE_SLOTS];
   logic [KIND_W-1:0]   knd_ff [TABLE_SLOTS];
   logic [KIND_W-1:0]   knd_in [TABLE_SLOTS];
   logic [COUNT_W-1:0]  cnt_ff [TABLE_SLOTS];
   logic [COUNT_W-1:0]  cnt_in [TABLE_SLOTS];

   logic [CLASS_W-1:0]  key_cls_ff;
   logic [TYPE_W-1:0]   key_typ_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [LOOKUP_W-1:0] lookups_ff;
   logic [LOOKUP_W-1:0] lookup_base;
   logic [COUNT_W-1:0]  default_cnt_ff;
   logic [COUNT_W-1:0]  default_inc;

   logic                found_ff;
   logic [KIND_W-1:0]   pos_ff;
   logic [KIND_W-1:0]   hit_kind_ff;
   logic [KIND_W-1:0]   hit_pos_ff;
   logic [COUNT_W-1:0]  hit_cnt_ff;

   logic                head_match;
   logic                take_hit;
   logic [COUNT_W-1:0]  head_inc;

   logic                rsp_valid_ff;
   logic                rsp_matched_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [KIND_W-1:0]   rsp_pos_ff;
   logic [COUNT_W-1:0]  rsp_cnt_ff;

   // Test the slot at the head of the table against the captured key
   assign head_match = ((typ_ff[0] == key_typ_ff) || (typ_ff[0] == '0)) &&
                       ((cls_ff[0] == key_cls_ff) || (cls_ff[0] == '0));
   assign take_hit    = cmd.scan && head_match && !found_ff;
   assign head_inc    = sat_inc(cnt_ff[0]);
   assign default_inc = sat_inc(default_cnt_ff);
   assign lookup_base = status.need_sort ? '0 : lookups_ff;

   assign status.need_sort = lookups_ff > {1'b0, limit_ff};
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // Next table contents: rotate during a scan, compare-and-swap during a sort
   always_comb begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         cls_in[i] = cls_ff[i];
         typ_in[i] = typ_ff[i];
         knd_in[i] = knd_ff[i];
         cnt_in[i] = cnt_ff[i];
      end
      if (cmd.scan) begin
         for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
            cls_in[i] = cls_ff[i+1];
            typ_in[i] = typ_ff[i+1];
            knd_in[i] = knd_ff[i+1];
            cnt_in[i] = cnt_ff[i+1];
         end
         cls_in[TABLE_SLOTS-1] = cls_ff[0];
         typ_in[TABLE_SLOTS-1] = typ_ff[0];
         knd_in[TABLE_SLOTS-1] = knd_ff[0];
         cnt_in[TABLE_SLOTS-1] = take_hit ? head_inc : cnt_ff[0];
      end else if (cmd.sort_pass) begin
         // swap only on a strictly smaller count so equal counts keep their order
         for (int j = 0; j < TABLE_SLOTS - 1; j++) begin
            if (((j & 1) == int'(cmd.sort_odd)) && (cnt_ff[j] < cnt_ff[j+1])) begin
               cls_in[j]   = cls_ff[j+1];
               typ_in[j]   = typ_ff[j+1];
               knd_in[j]   = knd_ff[j+1];
               cnt_in[j]   = cnt_ff[j+1];
               cls_in[j+1] = cls_ff[j];
               typ_in[j+1] = typ_ff[j];
               knd_in[j+1] = knd_ff[j];
               cnt_in[j+1] = cnt_ff[j];
            end
         end
         if (cmd.clear_counts) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               cnt_in[i] = '0;
            end
         end
      end
   end

   // Table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            cls_ff[i] <= init_class(i);
            typ_ff[i] <= init_type(i);
            knd_ff[i] <= KIND_W'(i);
            cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            cls_ff[i] <= cls_in[i];
            typ_ff[i] <= typ_in[i];
            knd_ff[i] <= knd_in[i];
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // Limit register, lookup counter, default count
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= LIMIT_RESET;
         lookups_ff     <= '0;
         default_cnt_ff <= '0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.load) begin
            lookups_ff <= (lookup_base == LOOKUP_MAX) ? lookup_base : lookup_base + 1'b1;
         end
         if (cmd.emit && !found_ff) begin
            default_cnt_ff <= default_inc;
         end
      end
   end

   // Capture the key, track the scan position and the first hit
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end else if (cmd.scan) begin
         pos_ff <= pos_ff + 1'b1;
         if (take_hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_cls_ff <= req_tdata[15:0];
         key_typ_ff <= req_tdata[31:16];
      end
      if (take_hit) begin
         hit_kind_ff <= knd_ff[0];
         hit_pos_ff  <= pos_ff;
         hit_cnt_ff  <= head_inc;
      end
   end

   // Response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_matched_ff <= found_ff;
         rsp_kind_ff    <= found_ff ? hit_kind_ff : DEFAULT_KIND;
         rsp_pos_ff     <= found_ff ? hit_pos_ff : '0;
         rsp_cnt_ff     <= found_ff ? hit_cnt_ff : default_inc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_cnt_ff, rsp_pos_ff, rsp_kind_ff};
   assign rsp_tuser  = rsp_matched_ff;

endmodule

// ===== hw/rtl/frequency_ordered_record_type_table.sv =====
// Record type table ordered by usage. An accepted request is looked up by the rotating
// scan, which moves one slot a cycle; when the lookup counter has passed the limit the
// table is re-sorted first (one odd-even pass per slot). The result goes to the response
// register, which waits while a response is still held at the output. A new request is
// taken only after the response of the last one has been loaded.
// Reset is synchronous and restores the initial table, counts and limit.
module frequency_ordered_record_type_table #(
   parameter int TABLE_SLOTS = 14
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: record_class [15:0], record_type [31:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // rsp_tdata: record_kind [3:0], slot_position [7:4], hit_count [39:8]
   // rsp_tuser: matched [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [0:0]  rsp_tuser,
   // re-sort threshold write port
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   import fortt_pkg::*;

   cmd_type    cmd;
   status_type status;

   fortt_ctrl #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fortt_datapath #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Take one request transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a lookup is in progress");

   // Never overwrite a response that is still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("response register overwritten");

   // Scan and sort never share a cycle
   a_scan_sort: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan && cmd.sort_pass))
      else $error("scan and sort pass in the same cycle");

   // Counts clear only at the end of a sort
   a_clear_sort: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_counts |-> cmd.sort_pass ##1 cmd.scan)
      else $error("count clear outside the last sort pass");

endmodule
